### src/assert_macros.svh
// assertion helpers, sampled on the rising clock edge, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ncctm_pkg.sv
package ncctm_pkg;

   localparam int IMAGE_ROWS_MAX = 4096;
   localparam int Q_FRAC = 14;
   localparam logic [14:0] Q_ONE = 15'd16384;

   localparam logic FUNC_TEMPLATE = 1'b0;
   localparam logic FUNC_IMAGE = 1'b1;

   localparam logic [2:0] CSR_IMAGE_WIDTH = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_TEMPLATE_WIDTH = 3'd2;
   localparam logic [2:0] CSR_TEMPLATE_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_MATCH_THRESHOLD = 3'd4;

   typedef struct packed {
      logic done;
      logic hit;
   } score_stat_type;

endpackage

### src/ncctm_wmul.sv
module ncctm_wmul #(
   parameter int OPW = 49
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [OPW-1:0]     a,
   input  logic [OPW-1:0]     b,
   output logic               done,
   output logic [2*OPW-1:0]   prod
);
   localparam int CNT_W = $clog2(OPW);

   logic [2*OPW-1:0] acc_ff;
   logic [2*OPW-1:0] ash_ff;
   logic [OPW-1:0]   bsh_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   // shift-add, one multiplier bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            acc_ff <= '0;
            ash_ff <= {{OPW{1'b0}}, a};
            bsh_ff <= b;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (bsh_ff[0]) begin
               acc_ff <= acc_ff + ash_ff;
            end
            ash_ff <= ash_ff << 1;
            bsh_ff <= bsh_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(OPW - 1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### src/ncctm_wdiv.sv
module ncctm_wdiv #(
   parameter int NUM_W = 126,
   parameter int DEN_W = 76
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W);

   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // restoring division, quotient bits shift in where the dividend shifts out
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge = trial >= {1'b0, den_ff};
   assign diff = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            rem_ff <= '0;
            quo_ff <= num;
            den_ff <= den;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;

endmodule

### src/ncctm_window.sv
module ncctm_window #(
   parameter int MAX_IW = 1024,
   parameter int MAX_TH = 32,
   parameter int MAXN = 1024,
   parameter int COL_W = 10,
   parameter int LINE_W = 5,
   parameter int TA_W = 10,
   parameter int LA_W = 15,
   parameter int S1_W = 19,
   parameter int S2_W = 27
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              tpl_we,
   input  logic [TA_W-1:0]   tpl_waddr,
   input  logic              img_we,
   input  logic [LINE_W-1:0] img_line,
   input  logic [COL_W-1:0]  img_col,
   input  logic [7:0]        wdata,
   input  logic              go,
   input  logic [LINE_W-1:0] line0,
   input  logic [COL_W-1:0]  left,
   input  logic [5:0]        tw,
   input  logic [5:0]        th,
   output logic              done,
   output logic [S1_W-1:0]   sx,
   output logic [S2_W-1:0]   sxx,
   output logic [S2_W-1:0]   sxt
);
   logic [7:0] tpl_mem [MAXN];
   logic [7:0] img_mem [MAX_TH*MAX_IW];

   logic              issue_ff;
   logic [5:0]        pc_ff;
   logic [5:0]        qc_ff;
   logic [LINE_W-1:0] line_ff;
   logic [COL_W-1:0]  left_ff;
   logic [TA_W-1:0]   taddr_ff;
   logic              rv_ff;
   logic              rl_ff;
   logic              done_ff;
   logic [7:0]        x_rd_ff;
   logic [7:0]        t_rd_ff;
   logic [S1_W-1:0]   sx_ff;
   logic [S2_W-1:0]   sxx_ff;
   logic [S2_W-1:0]   sxt_ff;
   logic [LA_W-1:0]   img_waddr;
   logic [LA_W-1:0]   img_raddr;
   logic              last;
   logic [15:0]       xx;
   logic [15:0]       xt;

   assign img_waddr = LA_W'(img_line) * LA_W'(MAX_IW) + LA_W'(img_col);
   assign img_raddr = LA_W'(line_ff) * LA_W'(MAX_IW) + LA_W'(left_ff) + LA_W'(qc_ff);
   assign last = (pc_ff == th - 6'd1) && (qc_ff == tw - 6'd1);
   assign xx = x_rd_ff * x_rd_ff;
   assign xt = x_rd_ff * t_rd_ff;

   always_ff @(posedge clock) begin
      if (tpl_we) begin
         tpl_mem[tpl_waddr] <= wdata;
      end
      if (issue_ff) begin
         t_rd_ff <= tpl_mem[taddr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_waddr] <= wdata;
      end
      if (issue_ff) begin
         x_rd_ff <= img_mem[img_raddr];
      end
   end

   // walk the window in raster order, one pixel pair per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         rv_ff <= 1'b0;
         rl_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         rv_ff <= issue_ff;
         rl_ff <= issue_ff && last;
         done_ff <= rl_ff;
         if (go) begin
            issue_ff <= 1'b1;
            pc_ff <= '0;
            qc_ff <= '0;
            line_ff <= line0;
            left_ff <= left;
            taddr_ff <= '0;
            sx_ff <= '0;
            sxx_ff <= '0;
            sxt_ff <= '0;
         end else begin
            if (issue_ff) begin
               taddr_ff <= taddr_ff + 1'b1;
               if (last) begin
                  issue_ff <= 1'b0;
               end else if (qc_ff == tw - 6'd1) begin
                  qc_ff <= '0;
                  pc_ff <= pc_ff + 6'd1;
                  line_ff <= (line_ff == LINE_W'(MAX_TH - 1)) ? '0 : line_ff + 1'b1;
               end else begin
                  qc_ff <= qc_ff + 6'd1;
               end
            end
            if (rv_ff) begin
               sx_ff <= sx_ff + S1_W'(x_rd_ff);
               sxx_ff <= sxx_ff + S2_W'(xx);
               sxt_ff <= sxt_ff + S2_W'(xt);
            end
         end
      end
   end

   assign done = done_ff;
   assign sx = sx_ff;
   assign sxx = sxx_ff;
   assign sxt = sxt_ff;

endmodule

### src/ncctm_score.sv
module ncctm_score #(
   parameter int N_W = 11,
   parameter int S1_W = 19,
   parameter int S2_W = 27
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [N_W-1:0]             n,
   input  logic [S1_W-1:0]            sx,
   input  logic [S1_W-1:0]            st,
   input  logic [S2_W-1:0]            sxx,
   input  logic [S2_W-1:0]            sxt,
   input  logic [S2_W-1:0]            stt,
   input  logic signed [15:0]         thr,
   output ncctm_pkg::score_stat_type  stat,
   output logic signed [15:0]         score
);
   import ncctm_pkg::*;

   localparam int PW = N_W + S2_W;
   localparam int OPW = N_W + PW;
   localparam int DVW = 2 * OPW + 2 * Q_FRAC;
   localparam int QN_W = 15 + N_W;
   localparam int QS_W = 2 * QN_W;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_DIFF = 11'b00000000010,
      ST_CHK  = 11'b00000000100,
      ST_AB   = 11'b00000001000,
      ST_R0   = 11'b00000010000,
      ST_R2   = 11'b00000100000,
      ST_DIV  = 11'b00001000000,
      ST_QM   = 11'b00010000000,
      ST_QS   = 11'b00100000000,
      ST_QC   = 11'b01000000000,
      ST_FIN  = 11'b10000000000
   } state_type;

   state_type         state_ff;
   logic [PW-1:0]     nsxt_ff, sxst_ff, nsxx_ff, sxsx_ff, nstt_ff, stst_ff;
   logic [PW-1:0]     nsxt_in, sxst_in, nsxx_in, sxsx_in, nstt_in, stst_in;
   logic signed [PW:0] p_ff, a_ff, b_ff;
   logic signed [PW:0] p_neg;
   logic [PW-1:0]     mag;
   logic [2*PW-1:0]   ab_ff;
   logic [OPW-1:0]    mul_a_ff, mul_b_ff;
   logic              mul_go_ff, div_go_ff;
   logic              mul_done, div_done;
   logic [2*OPW-1:0]  mul_prod;
   logic [DVW-1:0]    num_ff, d_ff, quo;
   logic [3:0]        k_ff;
   logic [14:0]       q_ff, cand_in;
   logic [QN_W-1:0]   mq_ff;
   logic [QS_W-1:0]   sq_ff;
   logic              ok_ff;
   logic              pass;

   assign nsxt_in = n * sxt;
   assign sxst_in = sx * st;
   assign nsxx_in = n * sxx;
   assign sxsx_in = sx * sx;
   assign nstt_in = n * stt;
   assign stst_in = st * st;
   assign p_neg = -p_ff;
   assign mag = p_ff[PW] ? p_neg[PW-1:0] : p_ff[PW-1:0];
   // first trial is full scale, then greedy bits from the top
   assign cand_in = (k_ff == 4'd14) ? Q_ONE : (q_ff | (15'd1 << k_ff));
   assign pass = !q_ff[14] && (DVW'(sq_ff) <= d_ff);

   ncctm_wmul #(.OPW(OPW)) u_wmul (
      .clock(clock), .reset(reset), .go(mul_go_ff), .a(mul_a_ff), .b(mul_b_ff),
      .done(mul_done), .prod(mul_prod)
   );

   ncctm_wdiv #(.NUM_W(DVW), .DEN_W(2 * PW)) u_wdiv (
      .clock(clock), .reset(reset), .go(div_go_ff), .num(num_ff), .den(ab_ff),
      .done(div_done), .quo(quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (go) begin
                  nsxt_ff <= nsxt_in;
                  sxst_ff <= sxst_in;
                  nsxx_ff <= nsxx_in;
                  sxsx_ff <= sxsx_in;
                  nstt_ff <= nstt_in;
                  stst_ff <= stst_in;
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               p_ff <= $signed({1'b0, nsxt_ff}) - $signed({1'b0, sxst_ff});
               a_ff <= $signed({1'b0, nsxx_ff}) - $signed({1'b0, sxsx_ff});
               b_ff <= $signed({1'b0, nstt_ff}) - $signed({1'b0, stst_ff});
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               // a flat window or a flat template gives no score
               ok_ff <= (a_ff > 0) && (b_ff > 0);
               if ((a_ff > 0) && (b_ff > 0)) begin
                  mul_a_ff <= OPW'(a_ff[PW-1:0]);
                  mul_b_ff <= OPW'(b_ff[PW-1:0]);
                  mul_go_ff <= 1'b1;
                  state_ff <= ST_AB;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_AB: begin
               if (mul_done) begin
                  ab_ff <= mul_prod[2*PW-1:0];
                  mul_a_ff <= OPW'(n - 1'b1);
                  mul_b_ff <= OPW'(mag);
                  mul_go_ff <= 1'b1;
                  state_ff <= ST_R0;
               end
            end
            ST_R0: begin
               if (mul_done) begin
                  mul_a_ff <= mul_prod[OPW-1:0];
                  mul_b_ff <= mul_prod[OPW-1:0];
                  mul_go_ff <= 1'b1;
                  state_ff <= ST_R2;
               end
            end
            ST_R2: begin
               if (mul_done) begin
                  num_ff <= {mul_prod, {(2 * Q_FRAC){1'b0}}};
                  div_go_ff <= 1'b1;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  d_ff <= quo;
                  q_ff <= '0;
                  k_ff <= 4'd14;
                  state_ff <= ST_QM;
               end
            end
            ST_QM: begin
               mq_ff <= cand_in * n;
               state_ff <= ST_QS;
            end
            ST_QS: begin
               sq_ff <= mq_ff * mq_ff;
               state_ff <= ST_QC;
            end
            ST_QC: begin
               if (pass) begin
                  q_ff <= cand_in;
               end
               if (k_ff == 4'd0) begin
                  state_ff <= ST_FIN;
               end else begin
                  k_ff <= k_ff - 4'd1;
                  state_ff <= ST_QM;
               end
            end
            ST_FIN: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign score = p_ff[PW] ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   assign stat.done = (state_ff == ST_FIN);
   assign stat.hit = ok_ff && (score > thr);

endmodule

### src/ncc_template_match.sv
// channel   ports                          transfer
// request   start, busy, req_*             start high while busy low
// response  rsp_strobe, rsp_*              rsp_strobe high, one cycle, no backpressure
// csr       csr_valid, csr_ready, csr_*    csr_valid and csr_ready high
//
// template pixels and pixels that complete no window leave busy low.
// a pixel that completes a window holds busy while the window is summed, one stored
// pixel pair per cycle through the memory read ports, and then scored with three
// shift-add multiplies, a restoring divide and 15 trial squarings.
// synchronous active-high reset clears counters and sums; the memories are not cleared.
// results cannot be stalled; each is shown for exactly one cycle.
`include "assert_macros.svh"

module ncc_template_match #(
   parameter int MAX_IMAGE_WIDTH = 1024,
   parameter int MAX_TEMPLATE_WIDTH = 32,
   parameter int MAX_TEMPLATE_HEIGHT = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_func,
   input  logic [7:0]                            req_pixel_value,
   output logic                                  rsp_strobe,
   output logic [11:0]                           rsp_window_row,
   output logic [$clog2(MAX_IMAGE_WIDTH)-1:0]    rsp_window_col,
   output logic signed [15:0]                    rsp_score,
   output logic [22:0]                           rsp_match_number,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [2:0]                            csr_index,
   input  logic [15:0]                           csr_data
);
   import ncctm_pkg::*;

   localparam int COL_W = $clog2(MAX_IMAGE_WIDTH);
   localparam int TWC = (MAX_TEMPLATE_WIDTH > 63) ? 63 : MAX_TEMPLATE_WIDTH;
   localparam int THC = (MAX_TEMPLATE_HEIGHT > 63) ? 63 : MAX_TEMPLATE_HEIGHT;
   localparam int MAXN = TWC * THC;
   localparam int N_W = $clog2(MAXN + 1);
   localparam int TA_W = (MAXN > 1) ? $clog2(MAXN) : 1;
   localparam int LINE_W = (MAX_TEMPLATE_HEIGHT > 1) ? $clog2(MAX_TEMPLATE_HEIGHT) : 1;
   localparam int LA_W = $clog2(MAX_TEMPLATE_HEIGHT * MAX_IMAGE_WIDTH);
   localparam int S1_W = 8 + N_W;
   localparam int S2_W = 16 + N_W;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_ACC   = 3'b010,
      PH_SCORE = 3'b100
   } phase_type;

   phase_type           phase_ff;
   logic [10:0]         image_width_ff;
   logic [12:0]         image_height_ff;
   logic [5:0]          template_width_ff;
   logic [5:0]          template_height_ff;
   logic signed [15:0]  match_threshold_ff;
   logic [11:0]         row_ff;
   logic [COL_W-1:0]    col_ff;
   logic [LINE_W-1:0]   line_ff;
   logic [22:0]         match_cnt_ff;
   logic [N_W-1:0]      tload_ff;
   logic [S1_W-1:0]     tsum_ff;
   logic [S2_W-1:0]     tsq_ff;
   logic [11:0]         top_ff;
   logic [COL_W-1:0]    left_ff;
   logic [LINE_W-1:0]   line0_ff;
   logic                fend_ff;
   logic                win_go_ff;
   logic                score_go_ff;
   logic                rsp_strobe_ff;
   logic [11:0]         rsp_row_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic signed [15:0]  rsp_score_ff;
   logic [22:0]         rsp_num_ff;

   logic [10:0]         iw;
   logic [12:0]         ih;
   logic [5:0]          tw, th;
   logic [N_W-1:0]      n;
   logic                accept;
   logic                tpl_we, img_we;
   logic [N_W-1:0]      lc, lc1, tload_in;
   logic [S1_W-1:0]     tsum_base;
   logic [S2_W-1:0]     tsq_base;
   logic [15:0]         vv;
   logic [COL_W:0]      col1;
   logic [12:0]         row1;
   logic                col_wrap, row_wrap, win;
   logic [LINE_W:0]     line0_sum;
   logic [LINE_W-1:0]   line0_in;
   logic                win_done;
   logic [S1_W-1:0]     wsx;
   logic [S2_W-1:0]     wsxx, wsxt;
   score_stat_type      stat;
   logic signed [15:0]  score;

   assign iw = (image_width_ff == 11'd0) ? 11'd1 :
               (image_width_ff > MAX_IMAGE_WIDTH) ? 11'(MAX_IMAGE_WIDTH) : image_width_ff;
   assign ih = (image_height_ff == 13'd0) ? 13'd1 :
               (image_height_ff > IMAGE_ROWS_MAX) ? 13'(IMAGE_ROWS_MAX) : image_height_ff;
   assign tw = (template_width_ff == 6'd0) ? 6'd1 :
               (template_width_ff > MAX_TEMPLATE_WIDTH) ? 6'(MAX_TEMPLATE_WIDTH) :
               template_width_ff;
   assign th = (template_height_ff == 6'd0) ? 6'd1 :
               (template_height_ff > MAX_TEMPLATE_HEIGHT) ? 6'(MAX_TEMPLATE_HEIGHT) :
               template_height_ff;
   assign n = N_W'(tw * th);

   assign accept = start && !busy;
   assign tpl_we = accept && (req_func == FUNC_TEMPLATE);
   assign img_we = accept && (req_func == FUNC_IMAGE);

   // template load position, restarted when it lies beyond the template
   assign lc = (tload_ff >= n) ? '0 : tload_ff;
   assign lc1 = lc + 1'b1;
   assign tload_in = (lc1 >= n) ? '0 : lc1;
   assign tsum_base = (lc == '0) ? '0 : tsum_ff;
   assign tsq_base = (lc == '0) ? '0 : tsq_ff;
   assign vv = req_pixel_value * req_pixel_value;

   assign col1 = {1'b0, col_ff} + 1'b1;
   assign row1 = {1'b0, row_ff} + 1'b1;
   assign col_wrap = col1 >= iw;
   assign row_wrap = row1 >= ih;
   assign win = (n > 1) && (row1 >= th) && (col1 >= tw);

   // ring line of the window's top row
   assign line0_sum = (LINE_W + 1)'(line_ff) + (LINE_W + 1)'(MAX_TEMPLATE_HEIGHT)
                      - (LINE_W + 1)'(th) + 1'b1;
   assign line0_in = (line0_sum >= (LINE_W + 1)'(MAX_TEMPLATE_HEIGHT)) ?
                     LINE_W'(line0_sum - (LINE_W + 1)'(MAX_TEMPLATE_HEIGHT)) :
                     LINE_W'(line0_sum);

   ncctm_window #(
      .MAX_IW(MAX_IMAGE_WIDTH), .MAX_TH(MAX_TEMPLATE_HEIGHT), .MAXN(MAXN),
      .COL_W(COL_W), .LINE_W(LINE_W), .TA_W(TA_W), .LA_W(LA_W),
      .S1_W(S1_W), .S2_W(S2_W)
   ) u_window (
      .clock(clock), .reset(reset),
      .tpl_we(tpl_we), .tpl_waddr(TA_W'(lc)),
      .img_we(img_we), .img_line(line_ff), .img_col(col_ff),
      .wdata(req_pixel_value),
      .go(win_go_ff), .line0(line0_ff), .left(left_ff), .tw(tw), .th(th),
      .done(win_done), .sx(wsx), .sxx(wsxx), .sxt(wsxt)
   );

   ncctm_score #(.N_W(N_W), .S1_W(S1_W), .S2_W(S2_W)) u_score (
      .clock(clock), .reset(reset), .go(score_go_ff), .n(n),
      .sx(wsx), .st(tsum_ff), .sxx(wsxx), .sxt(wsxt), .stt(tsq_ff),
      .thr(match_threshold_ff), .stat(stat), .score(score)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= 11'd1024;
         image_height_ff <= 13'd1024;
         template_width_ff <= 6'd32;
         template_height_ff <= 6'd32;
         match_threshold_ff <= 16'sd8192;
         phase_ff <= PH_IDLE;
         row_ff <= '0;
         col_ff <= '0;
         line_ff <= '0;
         match_cnt_ff <= '0;
         tload_ff <= '0;
         tsum_ff <= '0;
         tsq_ff <= '0;
         win_go_ff <= 1'b0;
         score_go_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         win_go_ff <= 1'b0;
         score_go_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:     image_width_ff <= csr_data[10:0];
               CSR_IMAGE_HEIGHT:    image_height_ff <= csr_data[12:0];
               CSR_TEMPLATE_WIDTH:  template_width_ff <= csr_data[5:0];
               CSR_TEMPLATE_HEIGHT: template_height_ff <= csr_data[5:0];
               CSR_MATCH_THRESHOLD: match_threshold_ff <= $signed(csr_data);
               default: begin
               end
            endcase
         end
         case (phase_ff)
            PH_IDLE: begin
               if (accept) begin
                  if (req_func == FUNC_TEMPLATE) begin
                     // a template pixel restarts the frame
                     row_ff <= '0;
                     col_ff <= '0;
                     line_ff <= '0;
                     match_cnt_ff <= '0;
                     tsum_ff <= tsum_base + S1_W'(req_pixel_value);
                     tsq_ff <= tsq_base + S2_W'(vv);
                     tload_ff <= tload_in;
                  end else begin
                     if (col_wrap) begin
                        col_ff <= '0;
                        if (row_wrap) begin
                           row_ff <= '0;
                           line_ff <= '0;
                        end else begin
                           row_ff <= row1[11:0];
                           line_ff <= (line_ff == LINE_W'(MAX_TEMPLATE_HEIGHT - 1)) ?
                                      '0 : line_ff + 1'b1;
                        end
                     end else begin
                        col_ff <= col1[COL_W-1:0];
                     end
                     if (win) begin
                        top_ff <= 12'(row1 - 13'(th));
                        left_ff <= COL_W'(col1 - (COL_W + 1)'(tw));
                        line0_ff <= line0_in;
                        fend_ff <= col_wrap && row_wrap;
                        win_go_ff <= 1'b1;
                        phase_ff <= PH_ACC;
                     end else if (col_wrap && row_wrap) begin
                        match_cnt_ff <= '0;
                     end
                  end
               end
            end
            PH_ACC: begin
               if (win_done) begin
                  score_go_ff <= 1'b1;
                  phase_ff <= PH_SCORE;
               end
            end
            PH_SCORE: begin
               if (stat.done) begin
                  if (stat.hit) begin
                     match_cnt_ff <= match_cnt_ff + 23'd1;
                     rsp_num_ff <= match_cnt_ff + 23'd1;
                     rsp_row_ff <= top_ff;
                     rsp_col_ff <= left_ff;
                     rsp_score_ff <= score;
                     rsp_strobe_ff <= 1'b1;
                  end
                  // frame end clears the count after this window's transfer
                  if (fend_ff) begin
                     match_cnt_ff <= '0;
                  end
                  phase_ff <= PH_IDLE;
               end
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign busy = (phase_ff != PH_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_window_row = rsp_row_ff;
   assign rsp_window_col = rsp_col_ff;
   assign rsp_score = rsp_score_ff;
   assign rsp_match_number = rsp_num_ff;

   `CHECK_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "back-to-back result strobes")
   `CHECK_NOW(a_score_above, rsp_strobe, rsp_score > match_threshold_ff,
              "result below threshold")
   `CHECK_NEXT(a_template_fast, accept && (req_func == FUNC_TEMPLATE), !busy,
               "template pixel left the block busy")
   `CHECK_NOW(a_number_nonzero, rsp_strobe, rsp_match_number != 23'd0,
              "result carries a zero match number")

endmodule
